// ----- src/hcmm_pkg.sv -----
package hcmm_pkg;

  // Default depth of the deferred write queue
  localparam int unsigned QueueDepthDefault = 4;

  // Address map boundaries (inclusive upper ends)
  localparam logic [15:0] ADDR_BOOT_END  = 16'h00FF;
  localparam logic [15:0] ADDR_CART_END  = 16'h7FFF;
  localparam logic [15:0] ADDR_VRAM_END  = 16'h9FFF;
  localparam logic [15:0] ADDR_XRAM_END  = 16'hBFFF;
  localparam logic [15:0] ADDR_WRAM_END  = 16'hDFFF;
  localparam logic [15:0] ADDR_ECHO_END  = 16'hFDFF;
  localparam logic [15:0] ADDR_OAM_END   = 16'hFE9F;
  localparam logic [15:0] ADDR_UNUSED_END = 16'hFEFF;
  localparam logic [15:0] ADDR_IO_END    = 16'hFF7F;
  localparam logic [15:0] ADDR_HRAM_END  = 16'hFFFE;

  // I/O register low bytes
  localparam logic [7:0] IO_JOYPAD     = 8'h00;
  localparam logic [7:0] IO_SERIAL_END = 8'h02;
  localparam logic [7:0] IO_TIMER_LO   = 8'h04;
  localparam logic [7:0] IO_TIMER_HI   = 8'h07;
  localparam logic [7:0] IO_IF         = 8'h0F;
  localparam logic [7:0] IO_VIDEO_LO   = 8'h40;
  localparam logic [7:0] IO_VIDEO_HI   = 8'h4B;
  localparam logic [7:0] IO_BOOT_OFF   = 8'h50;

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_QUEUE     = 3'd2,
    OP_COMMIT    = 3'd3,
    OP_BOOT_LOAD = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    TGT_NONE   = 3'd0,
    TGT_CART   = 3'd1,
    TGT_JOYPAD = 3'd2,
    TGT_SERIAL = 3'd3,
    TGT_TIMER  = 3'd4,
    TGT_VIDEO  = 3'd5
  } target_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic access;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic more;
  } dp_status_t;

endpackage

// ----- src/hcmm_ctrl.sv -----
module hcmm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  hcmm_pkg::dp_status_t   status_i,
  output hcmm_pkg::ctrl_cmd_t    cmd_o
);
  import hcmm_pkg::*;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_ACCESS;
      end
      ST_ACCESS: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.more ? ST_ACCESS : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_ACCESS: begin
        cmd_o.access = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ----- src/hcmm_dp.sv -----
module hcmm_dp #(
  parameter int unsigned QueueDepth = hcmm_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hcmm_pkg::ctrl_cmd_t  cmd_i,
  output hcmm_pkg::dp_status_t dp_status_o,
  input  logic [2:0]           operation_i,
  input  logic [15:0]          address_i,
  input  logic [7:0]           write_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           target_o,
  output logic                 is_write_o,
  output logic [15:0]          bus_address_o,
  output logic [7:0]           bus_data_o,
  output logic [7:0]           read_data_o,
  output logic                 status_o,
  output logic                 last_o
);
  import hcmm_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_BOOT,
    SEL_VRAM,
    SEL_WRAM,
    SEL_OAM,
    SEL_HRAM,
    SEL_IF,
    SEL_IE
  } rd_sel_e;

  // Map an I/O low byte to its peripheral, none when not forwarded
  function automatic target_e io_target(input logic [7:0] lo);
    target_e t;
    t = TGT_NONE;
    if (lo == IO_JOYPAD) t = TGT_JOYPAD;
    else if (lo <= IO_SERIAL_END) t = TGT_SERIAL;
    else if (lo >= IO_TIMER_LO && lo <= IO_TIMER_HI) t = TGT_TIMER;
    else if (lo >= IO_VIDEO_LO && lo <= IO_VIDEO_HI) t = TGT_VIDEO;
    return t;
  endfunction

  // Current item
  op_e         op_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;

  // Control registers
  logic [7:0]  if_q, ie_q;
  logic        boot_off_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;

  // Deferred write queue
  logic [15:0] q_addr [QueueDepth];
  logic [7:0]  q_data [QueueDepth];

  // Stores
  logic [7:0] vram [8192];
  logic [7:0] wram [8192];
  logic [7:0] oam  [160];
  logic [7:0] hram [127];
  logic [7:0] boot [256];
  logic [7:0] vram_rd_q, wram_rd_q, oam_rd_q, hram_rd_q, boot_rd_q;

  // Access stage results
  target_e     stg_tgt_q;
  logic        stg_wr_q;
  logic [15:0] stg_badr_q;
  logic [7:0]  stg_bdat_q;
  logic        stg_status_q;
  rd_sel_e     stg_sel_q;

  // Output register
  logic        out_valid_q;
  target_e     out_tgt_q;
  logic        out_wr_q;
  logic [15:0] out_badr_q;
  logic [7:0]  out_bdat_q;
  logic [7:0]  out_rdat_q;
  logic        out_status_q;
  logic        out_last_q;

  // Decode signals
  logic [15:0] a;
  logic [7:0]  d;
  logic [7:0]  lo;
  target_e     io_t;
  logic        is_rd, is_wr;
  target_e     acc_tgt;
  logic        acc_wr;
  logic [15:0] acc_badr;
  logic [7:0]  acc_bdat;
  logic        acc_status;
  rd_sel_e     acc_sel;
  logic        vram_we, wram_we, oam_we, hram_we, boot_we, if_we, ie_we;
  logic        boot_off_set, push;
  logic        more;
  logic        out_free;
  logic [7:0]  rdat;

  // Select the access source: queue entry on commit, else the item
  always_comb begin
    if (op_q == OP_COMMIT) begin
      a = q_addr[idx_q];
      d = q_data[idx_q];
    end else begin
      a = addr_q;
      d = data_q;
    end
  end

  assign lo    = a[7:0];
  assign io_t  = io_target(lo);
  assign is_rd = (op_q == OP_READ);
  assign is_wr = (op_q == OP_WRITE) || (op_q == OP_COMMIT && count_q != '0);
  assign more  = (op_q == OP_COMMIT) && ((CntW'(idx_q) + CntW'(1)) < count_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign dp_status_o.out_free = out_free;
  assign dp_status_o.more     = more;

  // Decode the access
  always_comb begin
    acc_tgt      = TGT_NONE;
    acc_wr       = 1'b0;
    acc_badr     = '0;
    acc_bdat     = '0;
    acc_status   = 1'b0;
    acc_sel      = SEL_NONE;
    vram_we      = 1'b0;
    wram_we      = 1'b0;
    oam_we       = 1'b0;
    hram_we      = 1'b0;
    boot_we      = 1'b0;
    if_we        = 1'b0;
    ie_we        = 1'b0;
    boot_off_set = 1'b0;
    push         = 1'b0;
    if (is_rd) begin
      if (a <= ADDR_BOOT_END && !boot_off_q) begin
        acc_sel = SEL_BOOT;
      end else if (a <= ADDR_CART_END) begin
        acc_tgt  = TGT_CART;
        acc_badr = a;
      end else if (a <= ADDR_VRAM_END) begin
        acc_sel = SEL_VRAM;
      end else if (a <= ADDR_XRAM_END) begin
        acc_tgt  = TGT_CART;
        acc_badr = a;
      end else if (a <= ADDR_ECHO_END) begin
        acc_sel = SEL_WRAM;
      end else if (a <= ADDR_OAM_END) begin
        acc_sel = SEL_OAM;
      end else if (a <= ADDR_UNUSED_END) begin
        acc_sel = SEL_NONE;
      end else if (a <= ADDR_IO_END) begin
        if (io_t != TGT_NONE) begin
          acc_tgt  = io_t;
          acc_badr = {8'h00, lo};
        end else if (lo == IO_IF) begin
          acc_sel = SEL_IF;
        end
      end else if (a <= ADDR_HRAM_END) begin
        acc_sel = SEL_HRAM;
      end else begin
        acc_sel = SEL_IE;
      end
    end else if (is_wr) begin
      acc_wr = 1'b1;
      if (a <= ADDR_CART_END || (a > ADDR_VRAM_END && a <= ADDR_XRAM_END)) begin
        acc_tgt  = TGT_CART;
        acc_badr = a;
        acc_bdat = d;
      end else if (a <= ADDR_VRAM_END) begin
        vram_we = 1'b1;
      end else if (a <= ADDR_ECHO_END) begin
        wram_we = 1'b1;
      end else if (a <= ADDR_OAM_END) begin
        oam_we = 1'b1;
      end else if (a <= ADDR_UNUSED_END) begin
        acc_tgt = TGT_NONE;
      end else if (a <= ADDR_IO_END) begin
        if (io_t != TGT_NONE) begin
          acc_tgt  = io_t;
          acc_badr = {8'h00, lo};
          acc_bdat = d;
        end else if (lo == IO_IF) begin
          if_we = 1'b1;
        end else if (lo == IO_BOOT_OFF && d != 8'h00) begin
          boot_off_set = 1'b1;
        end
      end else if (a <= ADDR_HRAM_END) begin
        hram_we = 1'b1;
      end else begin
        ie_we = 1'b1;
      end
    end else if (op_q == OP_QUEUE) begin
      if (count_q >= CntW'(QueueDepth)) acc_status = 1'b1;
      else push = 1'b1;
    end else if (op_q == OP_BOOT_LOAD) begin
      boot_we = 1'b1;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(operation_i);
      addr_q <= address_i;
      data_q <= write_data_i;
    end
  end

  // Update interrupt registers, overlay latch, queue count and commit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      if_q       <= '0;
      ie_q       <= '0;
      boot_off_q <= 1'b0;
      count_q    <= '0;
      idx_q      <= '0;
    end else begin
      if (cmd_i.access && if_we) if_q <= d;
      if (cmd_i.access && ie_we) ie_q <= d;
      if (cmd_i.access && boot_off_set) boot_off_q <= 1'b1;
      if (cmd_i.access && push) count_q <= count_q + CntW'(1);
      if (cmd_i.emit && op_q == OP_COMMIT) begin
        if (more) begin
          idx_q <= idx_q + IdxW'(1);
        end else begin
          idx_q   <= '0;
          count_q <= '0;
        end
      end
    end
  end

  // Store deferred writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.access && push) begin
      q_addr[count_q[IdxW-1:0]] <= addr_q;
      q_data[count_q[IdxW-1:0]] <= data_q;
    end
  end

  // Video RAM
  always_ff @(posedge clk_i) begin
    if (cmd_i.access && vram_we) vram[a[12:0]] <= d;
    if (cmd_i.access && acc_sel == SEL_VRAM) vram_rd_q <= vram[a[12:0]];
  end

  // Work RAM, echo region folds onto the same entries
  always_ff @(posedge clk_i) begin
    if (cmd_i.access && wram_we) wram[a[12:0]] <= d;
    if (cmd_i.access && acc_sel == SEL_WRAM) wram_rd_q <= wram[a[12:0]];
  end

  // Object RAM
  always_ff @(posedge clk_i) begin
    if (cmd_i.access && oam_we) oam[a[7:0]] <= d;
    if (cmd_i.access && acc_sel == SEL_OAM) oam_rd_q <= oam[a[7:0]];
  end

  // High RAM
  always_ff @(posedge clk_i) begin
    if (cmd_i.access && hram_we) hram[a[6:0]] <= d;
    if (cmd_i.access && acc_sel == SEL_HRAM) hram_rd_q <= hram[a[6:0]];
  end

  // Boot ROM store
  always_ff @(posedge clk_i) begin
    if (cmd_i.access && boot_we) boot[a[7:0]] <= d;
    if (cmd_i.access && acc_sel == SEL_BOOT) boot_rd_q <= boot[a[7:0]];
  end

  // Hold the decoded result for the emit step
  always_ff @(posedge clk_i) begin
    if (cmd_i.access) begin
      stg_tgt_q    <= acc_tgt;
      stg_wr_q     <= acc_wr;
      stg_badr_q   <= acc_badr;
      stg_bdat_q   <= acc_bdat;
      stg_status_q <= acc_status;
      stg_sel_q    <= acc_sel;
    end
  end

  // Pick the read byte
  always_comb begin
    case (stg_sel_q)
      SEL_BOOT: rdat = boot_rd_q;
      SEL_VRAM: rdat = vram_rd_q;
      SEL_WRAM: rdat = wram_rd_q;
      SEL_OAM:  rdat = oam_rd_q;
      SEL_HRAM: rdat = hram_rd_q;
      SEL_IF:   rdat = if_q;
      SEL_IE:   rdat = ie_q;
      default:  rdat = 8'h00;
    endcase
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_tgt_q    <= stg_tgt_q;
      out_wr_q     <= stg_wr_q;
      out_badr_q   <= stg_badr_q;
      out_bdat_q   <= stg_bdat_q;
      out_rdat_q   <= rdat;
      out_status_q <= stg_status_q;
      out_last_q   <= !more;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_o      = out_tgt_q;
  assign is_write_o    = out_wr_q;
  assign bus_address_o = out_badr_q;
  assign bus_data_o    = out_bdat_q;
  assign read_data_o   = out_rdat_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

endmodule

// ----- src/handheld_console_memory_map_unit.sv -----
// Channel  | Direction | Handshake                 | Payload
// input    | in        | in_valid_i / in_stall_o   | operation_i, address_i, write_data_i
// result   | out       | out_valid_o / out_stall_i | target_o, is_write_o, bus_address_o,
//          |           |                           | bus_data_o, read_data_o, status_o, last_o
//
// An item goes through accept, store access and result load; the registered read port of
// the stores sets the access-to-result step. A commit repeats access and result load per
// further queued write. A new item is taken while the last result waits on out_stall_i.
// Reset clears the interrupt registers, overlay latch and queue; stores are not cleared.
module handheld_console_memory_map_unit #(
  parameter int unsigned QueueDepth = hcmm_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  target_o,
  output logic        is_write_o,
  output logic [15:0] bus_address_o,
  output logic [7:0]  bus_data_o,
  output logic [7:0]  read_data_o,
  output logic        status_o,
  output logic        last_o
);
  import hcmm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  hcmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  hcmm_dp #(
    .QueueDepth (QueueDepth)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .dp_status_o   (dp_status),
    .operation_i   (operation_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .target_o      (target_o),
    .is_write_o    (is_write_o),
    .bus_address_o (bus_address_o),
    .bus_data_o    (bus_data_o),
    .read_data_o   (read_data_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

// ----- bench/handheld_console_memory_map_unit_tb.sv -----
module handheld_console_memory_map_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcmm_pkg::*;

  localparam int unsigned QDepth = QueueDepthDefault;
  localparam int unsigned RandomItems = 285;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic [15:0] IO_BASE = 16'hFF00;
  localparam logic [15:0] IF_ADR = {8'hFF, IO_IF};
  localparam logic [15:0] IE_ADR = 16'hFFFF;
  localparam logic [15:0] BOOT_OFF_ADR = {8'hFF, IO_BOOT_OFF};

  typedef struct packed {
    target_e     tgt;
    logic        wr;
    logic [15:0] badr;
    logic [7:0]  bdat;
    logic [7:0]  rdat;
    logic        st;
    logic        lst;
  } bus_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] adr;
    logic [7:0]  dat;
    bit          drain;
  } bus_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  operation_i = '0;
  logic [15:0] address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  target_o;
  logic        is_write_o;
  logic [15:0] bus_address_o;
  logic [7:0]  bus_data_o;
  logic [7:0]  read_data_o;
  logic        status_o;
  logic        last_o;

  handheld_console_memory_map_unit #(
    .QueueDepth(QDepth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .target_o     (target_o),
    .is_write_o   (is_write_o),
    .bus_address_o(bus_address_o),
    .bus_data_o   (bus_data_o),
    .read_data_o  (read_data_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  // Shadow of the decoder state, advanced on each accepted transfer
  logic [7:0]  vram_img [8192];
  logic [7:0]  wram_img [8192];
  logic [7:0]  oam_img [256];
  logic [7:0]  hram_img [128];
  logic [7:0]  boot_img [256];
  logic [7:0]  if_reg = '0;
  logic [7:0]  ie_reg = '0;
  logic        boot_locked_out = 1'b0;
  logic [15:0] defer_adr [$];
  logic [7:0]  defer_dat [$];

  bus_result_t results_due [$];
  bus_item_t   stim_q [$];
  int          results_owed;
  int          results_taken;
  int          mismatches = 0;

  // Stimulus-side view of which store entries hold data, so reads stay legal
  bit          vram_filled [8192];
  bit          wram_filled [8192];
  bit          oam_filled [256];
  bit          hram_filled [128];
  bit          boot_filled [256];
  bit          plan_overlay_off = 1'b0;
  logic [15:0] plan_defer_a [$];
  logic [7:0]  plan_defer_d [$];
  logic [15:0] readable [$];
  int          items_planned = 0;

  initial begin : clock_gen
    forever #2 clk_i = ~clk_i;
  end

  function automatic target_e io_unit(logic [7:0] lo);
    if (lo == IO_JOYPAD) return TGT_JOYPAD;
    if (lo <= IO_SERIAL_END) return TGT_SERIAL;
    if (lo >= IO_TIMER_LO && lo <= IO_TIMER_HI) return TGT_TIMER;
    if (lo >= IO_VIDEO_LO && lo <= IO_VIDEO_HI) return TGT_VIDEO;
    return TGT_NONE;
  endfunction

  function automatic bus_result_t read_effect(logic [15:0] a);
    bus_result_t r;
    target_e t;
    r = '0;
    if (a <= ADDR_BOOT_END && !boot_locked_out) begin
      r.rdat = boot_img[a[7:0]];
    end else if (a <= ADDR_CART_END || (a > ADDR_VRAM_END && a <= ADDR_XRAM_END)) begin
      r.tgt = TGT_CART;
      r.badr = a;
    end else if (a <= ADDR_VRAM_END) begin
      r.rdat = vram_img[a[12:0]];
    end else if (a <= ADDR_ECHO_END) begin
      // work RAM and its echo share the low 13 bits
      r.rdat = wram_img[a[12:0]];
    end else if (a <= ADDR_OAM_END) begin
      r.rdat = oam_img[a[7:0]];
    end else if (a <= ADDR_UNUSED_END) begin
      r.rdat = '0;
    end else if (a <= ADDR_IO_END) begin
      t = io_unit(a[7:0]);
      if (t != TGT_NONE) begin
        r.tgt = t;
        r.badr = {8'h00, a[7:0]};
      end else if (a[7:0] == IO_IF) begin
        r.rdat = if_reg;
      end
    end else if (a <= ADDR_HRAM_END) begin
      r.rdat = hram_img[a[6:0]];
    end else begin
      r.rdat = ie_reg;
    end
    return r;
  endfunction

  function automatic bus_result_t write_effect(logic [15:0] a, logic [7:0] d);
    bus_result_t r;
    target_e t;
    r = '0;
    r.wr = 1'b1;
    if (a <= ADDR_CART_END || (a > ADDR_VRAM_END && a <= ADDR_XRAM_END)) begin
      r.tgt = TGT_CART;
      r.badr = a;
      r.bdat = d;
    end else if (a <= ADDR_VRAM_END) begin
      vram_img[a[12:0]] = d;
    end else if (a <= ADDR_ECHO_END) begin
      wram_img[a[12:0]] = d;
    end else if (a <= ADDR_OAM_END) begin
      oam_img[a[7:0]] = d;
    end else if (a <= ADDR_UNUSED_END) begin
      // unused region swallows the write
    end else if (a <= ADDR_IO_END) begin
      t = io_unit(a[7:0]);
      if (t != TGT_NONE) begin
        r.tgt = t;
        r.badr = {8'h00, a[7:0]};
        r.bdat = d;
      end else if (a[7:0] == IO_IF) begin
        if_reg = d;
      end else if (a[7:0] == IO_BOOT_OFF && d != 8'h00) begin
        boot_locked_out = 1'b1;
      end
    end else if (a <= ADDR_HRAM_END) begin
      hram_img[a[6:0]] = d;
    end else begin
      ie_reg = d;
    end
    return r;
  endfunction

  // Decode one accepted transfer, queue its results, return how many
  function automatic int decode_item(logic [2:0] op, logic [15:0] a, logic [7:0] d);
    bus_result_t r;
    int n;
    int i;
    r = '0;
    n = 1;
    case (op)
      OP_READ: r = read_effect(a);
      OP_WRITE: r = write_effect(a, d);
      OP_QUEUE: begin
        if (defer_adr.size() >= QDepth) begin
          r.st = 1'b1;
        end else begin
          defer_adr.push_back(a);
          defer_dat.push_back(d);
        end
      end
      OP_COMMIT: begin
        if (defer_adr.size() != 0) begin
          n = defer_adr.size();
          for (i = 0; i < n; i++) begin
            r = write_effect(defer_adr[i], defer_dat[i]);
            r.lst = (i == n - 1);
            results_due.push_back(r);
          end
          defer_adr.delete();
          defer_dat.delete();
          return n;
        end
      end
      OP_BOOT_LOAD: boot_img[a[7:0]] = d;
      default: ;
    endcase
    r.lst = 1'b1;
    results_due.push_back(r);
    return n;
  endfunction

  function automatic int draw_wait(int n);
    // every third stretch of 32 transfers runs back to back
    return (n % 96 >= 64) ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic bit read_safe(logic [15:0] a);
    if (a <= ADDR_BOOT_END && !plan_overlay_off) return boot_filled[a[7:0]];
    if (a <= ADDR_CART_END) return 1'b1;
    if (a <= ADDR_VRAM_END) return vram_filled[a[12:0]];
    if (a <= ADDR_XRAM_END) return 1'b1;
    if (a <= ADDR_ECHO_END) return wram_filled[a[12:0]];
    if (a <= ADDR_OAM_END) return oam_filled[a[7:0]];
    if (a <= ADDR_IO_END) return 1'b1;
    if (a <= ADDR_HRAM_END) return hram_filled[a[6:0]];
    return 1'b1;
  endfunction

  task automatic mark_written(logic [15:0] a, logic [7:0] d);
    if (a > ADDR_CART_END && a <= ADDR_VRAM_END) begin
      vram_filled[a[12:0]] = 1'b1;
      readable.push_back(a);
    end else if (a > ADDR_XRAM_END && a <= ADDR_ECHO_END) begin
      wram_filled[a[12:0]] = 1'b1;
      readable.push_back(a);
    end else if (a > ADDR_ECHO_END && a <= ADDR_OAM_END) begin
      oam_filled[a[7:0]] = 1'b1;
      readable.push_back(a);
    end else if (a > ADDR_IO_END && a <= ADDR_HRAM_END) begin
      hram_filled[a[6:0]] = 1'b1;
      readable.push_back(a);
    end else if (a == BOOT_OFF_ADR && d != 8'h00) begin
      plan_overlay_off = 1'b1;
    end
  endtask

  task automatic add_item(logic [2:0] op, logic [15:0] a, logic [7:0] d);
    bus_item_t s;
    s.op = op;
    s.adr = a;
    s.dat = d;
    s.drain = (items_planned % 64 == 40);
    stim_q.push_back(s);
    items_planned++;
    case (op)
      OP_WRITE: mark_written(a, d);
      OP_QUEUE: begin
        if (plan_defer_a.size() < QDepth) begin
          plan_defer_a.push_back(a);
          plan_defer_d.push_back(d);
        end
      end
      OP_COMMIT: begin
        foreach (plan_defer_a[i]) mark_written(plan_defer_a[i], plan_defer_d[i]);
        plan_defer_a.delete();
        plan_defer_d.delete();
      end
      OP_BOOT_LOAD: begin
        boot_filled[a[7:0]] = 1'b1;
        readable.push_back({8'h00, a[7:0]});
      end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_addr();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 16'h00FF));
      1: return 16'($urandom_range(16'h0100, 16'h7FFF));
      2: return 16'($urandom_range(16'h8000, 16'h9FFF));
      3: return 16'($urandom_range(16'hA000, 16'hBFFF));
      4: return 16'($urandom_range(16'hC000, 16'hDFFF));
      5: return 16'($urandom_range(16'hE000, 16'hFDFF));
      6: return 16'($urandom_range(16'hFE00, 16'hFEFF));
      7: begin
        // favor the decoded I/O windows
        case ($urandom_range(0, 2))
          0: return IO_BASE + 16'($urandom_range(0, 16'h0F));
          1: return IO_BASE + 16'($urandom_range(16'h40, 16'h4F));
          default: return IO_BASE + 16'($urandom_range(0, 16'h7F));
        endcase
      end
      8: return 16'($urandom_range(16'hFF80, 16'hFFFF));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] safe_read_addr();
    logic [15:0] a;
    if (readable.size() != 0 && $urandom_range(0, 1) == 1) begin
      a = readable[$urandom_range(0, readable.size() - 1)];
      // flip between work RAM and its echo
      if (a > ADDR_XRAM_END && a <= ADDR_ECHO_END && a[12:0] < 13'h1E00
          && $urandom_range(0, 1) == 1)
        a = a ^ 16'h2000;
      return a;
    end
    do a = rand_addr(); while (!read_safe(a));
    return a;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: present queued items, predict each transfer as it is accepted
  int send_gap;
  int sent_count;
  always @(posedge clk_i or negedge rst_ni) begin
    int produced;
    bit took;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
      sent_count <= 0;
      results_owed <= 0;
    end else begin
      took = in_valid_i && !in_stall_o;
      produced = 0;
      if (took) begin
        produced = decode_item(operation_i, address_i, write_data_i);
        results_owed <= results_owed + produced;
      end
      if (took || !in_valid_i) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (stim_q.size() != 0 &&
                     !(stim_q[0].drain && results_owed + produced != results_taken)) begin
          in_valid_i <= 1'b1;
          operation_i <= stim_q[0].op;
          address_i <= stim_q[0].adr;
          write_data_i <= stim_q[0].dat;
          stim_q.pop_front();
          send_gap <= draw_wait(sent_count);
          sent_count <= sent_count + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, pace the stall line
  int  recv_wait;
  bit  long_hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    bus_result_t want;
    int next_wait;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait <= 0;
      long_hold_done <= 1'b0;
      results_taken <= 0;
    end else begin
      next_wait = recv_wait;
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: expected no result, actual %h %h %h %h %h %h %h",
                   $time, target_o, is_write_o, bus_address_o, bus_data_o, read_data_o,
                   status_o, last_o);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("target", want.tgt, target_o);
          check_field("is_write", want.wr, is_write_o);
          check_field("bus_address", want.badr, bus_address_o);
          check_field("bus_data", want.bdat, bus_data_o);
          check_field("read_data", want.rdat, read_data_o);
          check_field("status", want.st, status_o);
          check_field("last", want.lst, last_o);
        end
        results_taken <= results_taken + 1;
        next_wait = draw_wait(results_taken);
      end else if (next_wait != 0) begin
        next_wait--;
      end
      // hold off once for a long stretch so the block backs up
      if (!long_hold_done && results_taken == 120) begin
        long_hold_done <= 1'b1;
        next_wait = 400;
      end
      recv_wait <= next_wait;
      out_stall_i <= (next_wait != 0);
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : run_control
    logic [15:0] a;
    logic [7:0]  d;
    int n;
    int k;

    // Directed: map edges, every target, overlay, queue overflow, odd ops
    add_item(OP_READ, IE_ADR, 8'h00);
    add_item(OP_READ, IF_ADR, 8'h00);
    add_item(OP_BOOT_LOAD, 16'hFF05, 8'hFF);
    add_item(OP_READ, 16'h0005, 8'h00);
    add_item(OP_WRITE, 16'h0005, 8'hAA);
    add_item(OP_READ, ADDR_CART_END, 8'h00);
    add_item(OP_WRITE, ADDR_XRAM_END, 8'h01);
    add_item(OP_READ, ADDR_OAM_END + 16'h1, 8'h00);
    add_item(OP_WRITE, IO_BASE + 16'h03, 8'h80);
    add_item(OP_READ, {8'hFF, IO_JOYPAD}, 8'h00);
    add_item(OP_WRITE, {8'hFF, IO_SERIAL_END}, 8'h3C);
    add_item(OP_READ, {8'hFF, IO_TIMER_HI}, 8'h00);
    add_item(OP_WRITE, {8'hFF, IO_VIDEO_HI}, 8'hC3);
    add_item(OP_WRITE, IF_ADR, 8'hFF);
    add_item(OP_WRITE, IE_ADR, 8'h5A);
    add_item(OP_WRITE, BOOT_OFF_ADR, 8'h00);
    add_item(OP_READ, BOOT_OFF_ADR, 8'h00);
    add_item(OP_COMMIT, 16'h0000, 8'h00);
    add_item(OP_QUEUE, 16'h8000, 8'h11);
    add_item(OP_QUEUE, ADDR_HRAM_END, 8'h22);
    add_item(OP_QUEUE, 16'h0000, 8'h33);
    add_item(OP_QUEUE, {8'hFF, IO_VIDEO_LO}, 8'h44);
    add_item(OP_QUEUE, ADDR_WRAM_END, 8'h55);
    add_item(OP_COMMIT, 16'hFFFF, 8'h00);
    add_item(OP_UNUSED_HI, 16'hFFFF, 8'hFF);

    // Random: mostly write/read-back pairs and queue bursts, some noise
    while (items_planned < 25 + RandomItems) begin
      if (!plan_overlay_off && items_planned >= 200)
        add_item(OP_WRITE, BOOT_OFF_ADR, 8'($urandom_range(1, 255)));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = rand_addr();
          add_item(OP_WRITE, a, 8'($urandom()));
          add_item(OP_READ, read_safe(a) ? a : safe_read_addr(), 8'($urandom()));
        end
        3, 4: begin
          n = $urandom_range(1, QDepth + 2);
          for (k = 0; k < n; k++) add_item(OP_QUEUE, rand_addr(), 8'($urandom()));
          if ($urandom_range(0, 3) == 0) add_item(OP_READ, safe_read_addr(), 8'($urandom()));
          add_item(OP_COMMIT, 16'($urandom()), 8'($urandom()));
          add_item(OP_READ, safe_read_addr(), 8'($urandom()));
        end
        5: begin
          a = 16'($urandom());
          d = 8'($urandom());
          add_item(OP_BOOT_LOAD, a, d);
          add_item(OP_READ, {8'h00, a[7:0]}, 8'($urandom()));
        end
        6, 7: add_item(OP_READ, safe_read_addr(), 8'($urandom()));
        8: add_item(OP_WRITE, rand_addr(), 8'($urandom()));
        default: begin
          case ($urandom_range(0, 2))
            0: add_item(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 16'($urandom()),
                        8'($urandom()));
            1: add_item(OP_COMMIT, 16'($urandom()), 8'($urandom()));
            default: add_item(OP_QUEUE, 16'($urandom()), 8'($urandom()));
          endcase
        end
      endcase
    end

    // Hold reset, then release it on a rising edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain everything, then give the pipeline time to misbehave
    @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid_i || results_taken < results_owed)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (results_due.size() != 0) begin
      $display("%0t ns: %0d results expected but never seen, actual none", $time,
               results_due.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/hcmm_pkg.sv
src/hcmm_ctrl.sv
src/hcmm_dp.sv
src/handheld_console_memory_map_unit.sv
bench/handheld_console_memory_map_unit_tb.sv
